/* hw/rtl/adsrq_pkg.sv */
// Shared types and constants for the quadratic ADSR envelope generator.
// Used by adsrq_ctrl, adsrq_datapath and adsr_envelope_quadratic.
`default_nettype none

package adsrq_pkg;

    localparam int TIME_BITS_DEF   = 24;
    localparam int LEVEL_BITS_DEF  = 16;
    localparam int MIN_RELEASE_DEF = 44;

    localparam int PAD       = 16;
    localparam int COUNT_W   = 32;
    localparam int OP_W      = 2;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_DIVIDE,
        ST_SQUARE,
        ST_SCALE,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic stop;
        logic elapse;
        logic prep;
        logic div_step;
        logic square;
        logic scale;
        logic write;
    } adsrq_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            skip_div;
        logic            div_done;
        logic            out_free;
    } adsrq_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/adsrq_ctrl.sv */
// Sequencing state machine for the quadratic ADSR envelope generator.
// Depends on adsrq_pkg; drives the command struct of adsrq_datapath.
`default_nettype none

module adsrq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire adsrq_pkg::adsrq_stat_t stat,
    output adsrq_pkg::adsrq_cmd_t     cmd
);
    import adsrq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (stat.op == OP_START)
                begin
                    cmd.start = 1'b1;
                end
                else if (stat.op == OP_STOP)
                begin
                    cmd.stop = 1'b1;
                end
                else if (stat.op == OP_SAMPLE)
                begin
                    cmd.elapse = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (stat.skip_div)
                begin
                    state_next = ST_SQUARE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (stat.div_done)
                    begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (stat.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/adsrq_datapath.sv */
// Envelope state, configuration registers, restoring divider, multipliers
// and the output word register. Depends on adsrq_pkg; steered by adsrq_ctrl.
`default_nettype none

module adsrq_datapath #(
    parameter int TIME_BITS   = adsrq_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS  = adsrq_pkg::LEVEL_BITS_DEF,
    parameter int MIN_RELEASE = adsrq_pkg::MIN_RELEASE_DEF,
    parameter int CFG_W       = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wen,
    input  wire logic [adsrq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]                    cfg_data,
    input  wire logic [adsrq_pkg::OP_W-1:0]          in_op,
    input  wire logic [adsrq_pkg::COUNT_W-1:0]       in_count,
    input  wire adsrq_pkg::adsrq_cmd_t               cmd,
    output adsrq_pkg::adsrq_stat_t                   stat,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [LEVEL_BITS-1:0]                    out_level,
    output logic [adsrq_pkg::PHASE_W-1:0]            out_phase
);
    import adsrq_pkg::*;

    localparam int LEN_W     = (TIME_BITS + 1 > 10) ? TIME_BITS + 1 : 10;
    localparam int DEND_W    = LEN_W + 1;
    localparam int CMP_W     = COUNT_W + 1;
    localparam int DIV_STEPS = LEVEL_BITS - 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [LEVEL_BITS-1:0] ONE = {1'b1, {(LEVEL_BITS-1){1'b0}}};
    localparam logic [LEVEL_BITS-1:0] SUSTAIN_RST = ONE >> 1;

    logic [TIME_BITS-1:0]  attack_base_reg;
    logic [TIME_BITS-1:0]  decay_base_reg;
    logic [TIME_BITS-1:0]  release_base_reg;
    logic [LEVEL_BITS-1:0] sustain_level_reg;

    phase_t                phase_reg;
    logic [COUNT_W-1:0]    start_stamp_reg;
    logic [LEVEL_BITS-1:0] current_level_reg;
    logic [LEVEL_BITS-1:0] hold_level_reg;
    logic [LEN_W-1:0]      attack_len_reg;
    logic [LEN_W-1:0]      decay_len_reg;
    logic [LEN_W-1:0]      release_len_reg;
    logic [DEND_W-1:0]     decay_end_reg;

    logic [OP_W-1:0]       op_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    elapsed_reg;
    logic                  advance_reg;
    logic                  skip_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      rem_reg;
    logic [LEVEL_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [LEVEL_BITS-1:0] sq_reg;
    logic [LEVEL_BITS-1:0] prod_reg;

    logic                  out_valid_reg;
    logic [LEVEL_BITS-1:0] out_level_reg;
    phase_t                out_phase_reg;

    logic [COUNT_W-1:0]      t_sel;
    logic [LEN_W-1:0]        len_sel;
    logic                    sat;
    logic                    advance_sel;
    logic                    skip_sel;
    logic [LEN_W:0]          rem_shift;
    logic                    rem_ge;
    logic [2*LEVEL_BITS-1:0] sq_full;
    logic [LEVEL_BITS-1:0]   mult_a;
    logic [2*LEVEL_BITS-1:0] prod_full;
    logic [LEVEL_BITS-1:0]   lvl_decay;
    logic [LEVEL_BITS-1:0]   lvl_release;
    logic [LEVEL_BITS-1:0]   level_next;
    phase_t                  phase_next;
    logic [LEN_W-1:0]        release_start;
    logic [LEVEL_BITS-1:0]   hold_start;

    // Time and phase selection for the fraction of the current segment.
    always_comb
    begin
        t_sel       = elapsed_reg;
        len_sel     = release_len_reg;
        advance_sel = 1'b0;
        skip_sel    = 1'b0;
        case (phase_reg)
            PH_ATTACK:
            begin
                len_sel     = attack_len_reg;
                advance_sel = CMP_W'(elapsed_reg) >= CMP_W'(attack_len_reg);
            end
            PH_DECAY:
            begin
                t_sel       = elapsed_reg - COUNT_W'(attack_len_reg);
                len_sel     = decay_len_reg;
                advance_sel = CMP_W'(elapsed_reg) >= CMP_W'(decay_end_reg);
            end
            PH_RELEASE:
            begin
                len_sel = release_len_reg;
            end
            default:
            begin
                skip_sel = 1'b1;
            end
        endcase
        sat = CMP_W'(t_sel) >= CMP_W'(len_sel);
    end

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= (LEN_W + 1)'(len_reg);
    assign sq_full   = quo_reg * quo_reg;
    assign mult_a    = (phase_reg == PH_DECAY) ? ONE - hold_level_reg : hold_level_reg;
    assign prod_full = mult_a * sq_reg;

    assign release_start = (LEN_W'(release_base_reg) < LEN_W'(MIN_RELEASE))
                         ? LEN_W'(MIN_RELEASE) : LEN_W'(release_base_reg);
    assign hold_start    = (sustain_level_reg > ONE) ? ONE : sustain_level_reg;

    // New level and phase at the end of a sample request.
    always_comb
    begin
        lvl_decay   = ONE - prod_reg;
        lvl_release = hold_level_reg - prod_reg;
        level_next  = '0;
        phase_next  = PH_IDLE;
        case (phase_reg)
            PH_ATTACK:
            begin
                level_next = quo_reg;
                phase_next = advance_reg ? PH_DECAY : PH_ATTACK;
            end
            PH_DECAY:
            begin
                level_next = (lvl_decay < hold_level_reg) ? hold_level_reg : lvl_decay;
                phase_next = advance_reg ? PH_SUSTAIN : PH_DECAY;
            end
            PH_SUSTAIN:
            begin
                level_next = current_level_reg;
                phase_next = PH_SUSTAIN;
            end
            PH_RELEASE:
            begin
                level_next = lvl_release;
                phase_next = (lvl_release == '0) ? PH_IDLE : PH_RELEASE;
            end
            default:
            begin
                level_next = '0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_base_reg   <= '0;
            decay_base_reg    <= '0;
            release_base_reg  <= '0;
            sustain_level_reg <= SUSTAIN_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ATTACK:  attack_base_reg   <= cfg_data[TIME_BITS-1:0];
                CFG_DECAY:   decay_base_reg    <= cfg_data[TIME_BITS-1:0];
                CFG_RELEASE: release_base_reg  <= cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN: sustain_level_reg <= cfg_data[LEVEL_BITS-1:0];
                default:     sustain_level_reg <= sustain_level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            start_stamp_reg   <= '0;
            current_level_reg <= '0;
            hold_level_reg    <= '0;
            attack_len_reg    <= LEN_W'(PAD);
            decay_len_reg     <= LEN_W'(PAD);
            release_len_reg   <= LEN_W'(MIN_RELEASE);
            decay_end_reg     <= DEND_W'(2 * PAD);
        end
        else if (cmd.start)
        begin
            phase_reg         <= PH_ATTACK;
            start_stamp_reg   <= count_reg;
            current_level_reg <= '0;
            hold_level_reg    <= hold_start;
            attack_len_reg    <= LEN_W'(attack_base_reg) + LEN_W'(PAD);
            decay_len_reg     <= LEN_W'(decay_base_reg) + LEN_W'(PAD);
            release_len_reg   <= release_start;
            decay_end_reg     <= DEND_W'(attack_base_reg) + DEND_W'(decay_base_reg)
                               + DEND_W'(2 * PAD);
        end
        else if (cmd.stop)
        begin
            phase_reg       <= PH_RELEASE;
            start_stamp_reg <= count_reg;
            hold_level_reg  <= current_level_reg;
        end
        else if (cmd.write)
        begin
            phase_reg         <= phase_next;
            current_level_reg <= level_next;
        end
    end

    // Working registers of one sample request.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            count_reg <= in_count;
        end
        if (cmd.elapse)
        begin
            elapsed_reg <= count_reg - start_stamp_reg;
        end
        if (cmd.prep)
        begin
            advance_reg <= advance_sel;
            skip_reg    <= skip_sel || sat;
            len_reg     <= len_sel;
            rem_reg     <= t_sel[LEN_W-1:0];
            quo_reg     <= sat ? ONE : '0;
            cnt_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? LEN_W'(rem_shift - (LEN_W + 1)'(len_reg))
                              : rem_shift[LEN_W-1:0];
            quo_reg <= {quo_reg[LEVEL_BITS-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_full[2*LEVEL_BITS-2:LEVEL_BITS-1];
        end
        if (cmd.scale)
        begin
            prod_reg <= prod_full[2*LEVEL_BITS-2:LEVEL_BITS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            out_level_reg <= level_next;
            out_phase_reg <= phase_next;
        end
    end

    assign stat.op       = op_reg;
    assign stat.skip_div = skip_reg;
    assign stat.div_done = cnt_reg == CNT_W'(DIV_STEPS - 1);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_phase = out_phase_reg;

    a_write_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!out_valid_reg || out_ready))
        else $error("Output word overwritten before it was taken.");

    a_fraction_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.square |-> (quo_reg <= ONE))
        else $error("Fraction above full scale.");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_level_reg <= ONE))
        else $error("Output level above full scale.");

    a_idle_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> (out_phase_reg != PH_IDLE || out_level_reg == '0
                       || $past(phase_reg) == PH_RELEASE))
        else $error("Idle word carries a nonzero level.");

endmodule

`default_nettype wire

/* hw/rtl/adsr_envelope_quadratic.sv */
// Top level of the quadratic ADSR envelope generator: stream ports,
// configuration port, adsrq_ctrl and adsrq_datapath. Depends on adsrq_pkg.
`default_nettype none

// A note start or stop word is decoded and gives no result. A sample request
// steps through the prep, divide, square, scale and write states; the divide
// state runs the restoring divider, which finds one fraction bit per cycle, while the
// envelope is in attack, decay or release and the segment is not yet over;
// when the segment time is reached, and in idle or sustain, the divider is
// bypassed. The result word sits in an output register, so the next word is
// accepted while a result waits to be taken.
module adsr_envelope_quadratic #(
    parameter int TIME_BITS   = adsrq_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS  = adsrq_pkg::LEVEL_BITS_DEF,
    parameter int MIN_RELEASE = adsrq_pkg::MIN_RELEASE_DEF,
    parameter int CFG_W       = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS,
    parameter int OUT_W       = ((LEVEL_BITS + adsrq_pkg::PHASE_W + 7) / 8) * 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [adsrq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]                 cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_count
    input  wire logic [adsrq_pkg::COUNT_W-1:0]    s_axis_tdata,
    // operation
    input  wire logic [adsrq_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // level, phase_now, zero fill
    output logic [OUT_W-1:0]                      m_axis_tdata
);
    import adsrq_pkg::*;

    adsrq_cmd_t            cmd;
    adsrq_stat_t           stat;
    logic [LEVEL_BITS-1:0] out_level;
    logic [PHASE_W-1:0]    out_phase;

    adsrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    adsrq_datapath #(
        .TIME_BITS   (TIME_BITS),
        .LEVEL_BITS  (LEVEL_BITS),
        .MIN_RELEASE (MIN_RELEASE),
        .CFG_W       (CFG_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tuser),
        .in_count  (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_level (out_level),
        .out_phase (out_phase)
    );

    assign m_axis_tdata = OUT_W'({out_phase, out_level});

endmodule

`default_nettype wire

/* tb/adsr_envelope_quadratic_tb.sv */
// Self-checking testbench for adsr_envelope_quadratic: a directed table and random notes
// are checked word by word against typed table words or an envelope predictor kept
// in step with the block. Depends on adsrq_pkg and the RTL of adsr_envelope_quadratic.
module adsr_envelope_quadratic_tb;

    import adsrq_pkg::*;

    localparam int CFG_BITS  = (TIME_BITS_DEF > LEVEL_BITS_DEF) ? TIME_BITS_DEF : LEVEL_BITS_DEF;
    localparam int OUT_BITS  = ((LEVEL_BITS_DEF + PHASE_W + 7) / 8) * 8;
    localparam int ITEM_GOAL = 1100;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 600;
    localparam int REPORT_CAP    = 50;
    localparam longint unsigned FULL = 64'd1 << (LEVEL_BITS_DEF - 1);
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        logic [15:0] level;
        phase_t      phase_now;
    } envelope_word_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  sel;
        logic [31:0] value;
        bit          typed;
        logic [15:0] level;
        phase_t      phase_now;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_BITS-1:0]  cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [COUNT_W-1:0]   s_axis_tdata;
    logic [OP_W-1:0]      s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_BITS-1:0]  m_axis_tdata;

    adsr_envelope_quadratic DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state and its copy of the registers.
    logic [23:0] atk_base   = '0;
    logic [23:0] dcy_base   = '0;
    logic [23:0] rel_base   = '0;
    logic [15:0] sus_level  = 16'd16384;
    phase_t      env_phase  = PH_IDLE;
    logic [31:0] note_stamp = '0;
    logic [15:0] env_level  = '0;
    logic [15:0] held_level = '0;
    logic [24:0] atk_len    = 25'(PAD);
    logic [24:0] dcy_len    = 25'(PAD);
    logic [23:0] rel_len    = 24'(MIN_RELEASE_DEF);

    envelope_word_t envelope_owed[$];
    plan_row_t      plan[$];
    envelope_word_t typed_word;
    bit             use_typed = 1'b0;
    bit             hold_armed = 1'b0;
    int             mismatches = 0;
    int             words_sent = 0;
    int             burst_left = 0;
    logic [31:0]    tick = '0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint unsigned sat_fraction(input longint unsigned t,
                                                     input longint unsigned len);
        if (t >= len)
            return FULL;
        return (t * FULL) / len;
    endfunction

    function automatic longint unsigned square_q(input longint unsigned f);
        return (f * f) / FULL;
    endfunction

    task automatic step_envelope(input logic [1:0] op, input logic [31:0] cnt,
                                 output bit gives, output envelope_word_t word);
        logic [31:0] since;
        logic [31:0] into_decay;
        longint unsigned q;
        longint unsigned lv;
        gives = 1'b0;
        word.level = '0;
        word.phase_now = PH_IDLE;
        since = cnt - note_stamp;
        if (op == OP_START)
        begin
            note_stamp = cnt;
            atk_len = 25'(atk_base) + 25'(PAD);
            dcy_len = 25'(dcy_base) + 25'(PAD);
            rel_len = (rel_base < MIN_RELEASE_DEF) ? 24'(MIN_RELEASE_DEF) : rel_base;
            held_level = (sus_level > FULL) ? 16'(FULL) : sus_level;
            env_level = '0;
            env_phase = PH_ATTACK;
        end
        else if (op == OP_STOP)
        begin
            note_stamp = cnt;
            held_level = env_level;
            env_phase = PH_RELEASE;
        end
        else if (op == OP_SAMPLE)
        begin
            case (env_phase)
                PH_ATTACK:
                begin
                    env_level = 16'(sat_fraction(since, atk_len));
                    if (since >= atk_len)
                        env_phase = PH_DECAY;
                end
                PH_DECAY:
                begin
                    into_decay = since - 32'(atk_len);
                    q = square_q(sat_fraction(into_decay, dcy_len));
                    lv = FULL - ((FULL - held_level) * q) / FULL;
                    if (lv < held_level)
                        lv = held_level;
                    env_level = 16'(lv);
                    if (since >= atk_len + dcy_len)
                        env_phase = PH_SUSTAIN;
                end
                PH_SUSTAIN: ;
                PH_RELEASE:
                begin
                    q = square_q(sat_fraction(since, rel_len));
                    env_level = 16'(held_level - (held_level * q) / FULL);
                    if (env_level == 0)
                        env_phase = PH_IDLE;
                end
                default:
                begin
                    env_level = '0;
                    env_phase = PH_IDLE;
                end
            endcase
            gives = 1'b1;
            word.level = env_level;
            word.phase_now = env_phase;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (mismatches < REPORT_CAP)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        bit             gives;
        envelope_word_t fresh;
        envelope_word_t due;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ATTACK:  atk_base = cfg_data[23:0];
                CFG_DECAY:   dcy_base = cfg_data[23:0];
                CFG_RELEASE: rel_base = cfg_data[23:0];
                CFG_SUSTAIN: sus_level = cfg_data[15:0];
                default: ;
            endcase
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            step_envelope(s_axis_tuser, s_axis_tdata, gives, fresh);
            if (gives)
            begin
                if (use_typed)
                    envelope_owed.push_back(typed_word);
                else
                    envelope_owed.push_back(fresh);
            end
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (envelope_owed.size() == 0)
                report_mismatch("result word with none owed", 0, m_axis_tdata);
            else
            begin
                due = envelope_owed.pop_front();
                if (m_axis_tdata[15:0] !== due.level)
                    report_mismatch("level", due.level, m_axis_tdata[15:0]);
                if (m_axis_tdata[18:16] !== due.phase_now)
                    report_mismatch("phase", due.phase_now, m_axis_tdata[18:16]);
            end
        end
    end

    // The receiver stalls in modes of random length and once holds off for a long stretch.
    initial
    begin
        int  mode_left;
        int  stall_pct;
        int  hold_left;
        bit  hold_started;
        mode_left = 0;
        stall_pct = 0;
        hold_left = 0;
        hold_started = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_started)
            begin
                hold_started = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 100);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 80;
                    endcase
                end
                mode_left--;
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [31:0] cnt, input bit typed,
                             input logic [15:0] lvl, input phase_t ph);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= cnt;
        use_typed = typed;
        typed_word.level = lvl;
        typed_word.phase_now = ph;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op != OP_UNDEFINED)
            words_sent++;
    endtask

    task automatic offer(input logic [1:0] op, input logic [31:0] cnt);
        send_word(op, cnt, 1'b0, 16'd0, PH_IDLE);
    endtask

    task automatic settle_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (envelope_owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [1:0] sel, input logic [31:0] value,
                           input bit typed, input logic [15:0] lvl, input phase_t ph);
        plan_row_t row;
        row.kind = kind;
        row.sel = sel;
        row.value = value;
        row.typed = typed;
        row.level = lvl;
        row.phase_now = ph;
        plan.push_back(row);
    endtask

    function automatic int unsigned stride(input longint unsigned len);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32'(len);
            default: return $urandom_range(0, 32'(len / 3 + 1));
        endcase
    endfunction

    function automatic logic [23:0] pick_length();
        case ($urandom_range(0, 6))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2, 3: return 24'($urandom_range(0, 300));
            4: return 24'($urandom_range(0, 5000));
            5: return 24'($urandom);
            default: return 24'($urandom_range(40, 48));
        endcase
    endfunction

    function automatic logic [23:0] pick_sustain();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'(FULL);
            2: return 24'($urandom_range(32769, 65535));
            default: return 24'($urandom_range(0, 32768));
        endcase
    endfunction

    // A well-formed note: start, samples across attack and decay, some sustain,
    // stop, samples across release and often one past its end.
    task automatic play_note();
        longint unsigned rise;
        longint unsigned fall;
        rise = longint'(atk_base) + longint'(dcy_base) + 2 * PAD;
        fall = (rel_base < MIN_RELEASE_DEF) ? MIN_RELEASE_DEF : rel_base;
        offer(OP_START, tick);
        if ($urandom_range(0, 9) != 0)
        begin
            repeat ($urandom_range(1, 8))
            begin
                tick += stride(rise);
                offer(OP_SAMPLE, tick);
            end
            repeat ($urandom_range(0, 3))
            begin
                tick += stride(4 * rise);
                offer(OP_SAMPLE, tick);
            end
        end
        offer(OP_STOP, tick);
        repeat ($urandom_range(1, 6))
        begin
            tick += stride(fall);
            offer(OP_SAMPLE, tick);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            tick += 32'(fall);
            offer(OP_SAMPLE, tick);
            tick += $urandom_range(0, 100);
            offer(OP_SAMPLE, tick);
        end
    endtask

    task automatic make_noise();
        case ($urandom_range(0, 4))
            0:
            begin
                tick = $urandom;
                offer(OP_SAMPLE, tick);
            end
            1: offer(OP_UNDEFINED, $urandom);
            2: offer(OP_SAMPLE, tick - $urandom_range(1, 5000));
            3: offer(OP_STOP, tick);
            default:
            begin
                tick = $urandom;
                offer(OP_START, tick);
            end
        endcase
    endtask

    initial
    begin
        int phase_end;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;

        add_row(ROW_WORD, OP_SAMPLE,    32'd0,          1, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_UNDEFINED, 32'hFFFF_FFFF,  0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_STOP,      32'd100,        0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'd100,        1, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_START,     32'd1000,       0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'd1000,       1, 16'd0,     PH_ATTACK);
        add_row(ROW_WORD, OP_SAMPLE,    32'd1008,       0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'd1016,       1, 16'd32768, PH_DECAY);
        add_row(ROW_WORD, OP_SAMPLE,    32'd1024,       0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'd1032,       1, 16'd16384, PH_SUSTAIN);
        add_row(ROW_WORD, OP_SAMPLE,    32'd2000,       1, 16'd16384, PH_SUSTAIN);
        add_row(ROW_WORD, OP_STOP,      32'd2000,       0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'd2022,       0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'd2044,       1, 16'd0,     PH_IDLE);
        add_row(ROW_REG,  CFG_SUSTAIN,  32'h0000_FFFF,  0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_START,     32'hFFFF_FFF0,  0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'h0000_0000,  1, 16'd32768, PH_DECAY);
        add_row(ROW_WORD, OP_SAMPLE,    32'hFFFF_FFF8,  1, 16'd32768, PH_DECAY);
        add_row(ROW_WORD, OP_SAMPLE,    32'h0000_0010,  1, 16'd32768, PH_SUSTAIN);
        add_row(ROW_REG,  CFG_SUSTAIN,  32'd0,          0, 16'd0,     PH_IDLE);
        add_row(ROW_REG,  CFG_ATTACK,   32'h00FF_FFFF,  0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_START,     32'h8000_0000,  0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'h8000_0001,  0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'h7FFF_FFFF,  1, 16'd32768, PH_DECAY);
        add_row(ROW_WORD, OP_SAMPLE,    32'h7FFF_FFFF,  1, 16'd0,     PH_SUSTAIN);
        add_row(ROW_WORD, OP_STOP,      32'h7FFF_FFFF,  0, 16'd0,     PH_IDLE);
        add_row(ROW_WORD, OP_SAMPLE,    32'h7FFF_FFFF,  1, 16'd0,     PH_IDLE);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                settle_block();
                write_register(plan[i].sel, plan[i].value[23:0]);
            end
            else
                send_word(plan[i].sel, plan[i].value, plan[i].typed, plan[i].level,
                          plan[i].phase_now);
        end

        for (int p = 0; words_sent < ITEM_GOAL; p++)
        begin
            settle_block();
            if (p == 0)
            begin
                write_register(CFG_ATTACK, 24'hFF_FFFF);
                write_register(CFG_DECAY, 24'hFF_FFFF);
                write_register(CFG_RELEASE, 24'hFF_FFFF);
                write_register(CFG_SUSTAIN, 24'(FULL));
            end
            else if (p == 1)
            begin
                write_register(CFG_ATTACK, 24'd0);
                write_register(CFG_DECAY, 24'd0);
                write_register(CFG_RELEASE, 24'd0);
                write_register(CFG_SUSTAIN, 24'd0);
            end
            else
            begin
                write_register(CFG_ATTACK, pick_length());
                write_register(CFG_DECAY, pick_length());
                write_register(CFG_RELEASE, pick_length());
                write_register(CFG_SUSTAIN, pick_sustain());
            end
            if (p == 2)
                hold_armed = 1'b1;
            phase_end = words_sent + $urandom_range(80, 160);
            while (words_sent < phase_end && words_sent < ITEM_GOAL)
            begin
                if ($urandom_range(0, 9) < 8)
                    play_note();
                else
                    make_noise();
            end
        end

        settle_block();
        if (mismatches == 0 && envelope_owed.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
